/* hdl/drop_oldest_audio_fifo_defines.svh */
// assertion macros for the drop-oldest audio fifo checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef DROP_OLDEST_AUDIO_FIFO_DEFINES_SVH
`define DROP_OLDEST_AUDIO_FIFO_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define DOAF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("drop-oldest fifo check failed");

// consequent checked in the cycle after the antecedent
`define DOAF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("drop-oldest fifo check failed");

`endif

/* hdl/doaf_pkg.sv */
// shared types, constants and codes of the drop-oldest audio fifo
// used by the top level, its checker, the result checker and the testbench; no dependencies
package doaf_pkg;

    // sizing
    localparam int DEPTH     = 4096;
    localparam int MAX_BURST = 64;
    localparam int PTR_W     = $clog2(DEPTH);

    // field widths
    localparam int BYTE_W    = 8;
    localparam int MODE_W    = 2;
    localparam int BURST_W   = 7;
    localparam int LVL_W     = 13;
    localparam int PCT_W     = 7;
    localparam int STATUS_W  = 3;
    localparam int CNT_W     = 32;
    localparam int TOT_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = LVL_W + PCT_W;

    localparam int PERCENT   = 100;

    // item modes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STATS = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_WRITTEN  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_READ     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERRUN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STATS    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd2;

    // configuration reset values
    localparam logic [LVL_W-1:0] TARGET_RST = 13'd1024;
    localparam logic [LVL_W-1:0] MIN_RST    = 13'd256;
    localparam logic [LVL_W-1:0] MAX_RST    = 13'd3072;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BYTE_W-1:0]  write_byte;
        logic               chunk_start;
        logic [BURST_W-1:0] read_length;
        logic               may_wait;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_byte;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [LVL_W-1:0]    fill_level;
        logic [PCT_W-1:0]    fill_percent;
        logic                target_reached;
        logic                below_min;
        logic                above_max;
        logic [CNT_W-1:0]    overrun_count;
        logic [CNT_W-1:0]    underrun_count;
        logic [TOT_W-1:0]    bytes_written_total;
        logic [TOT_W-1:0]    bytes_read_total;
    } t_out_item;

    // ring pointer advance with wrap at the store depth
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

/* hdl/drop_oldest_audio_fifo.sv */
// drop-oldest audio byte fifo, top level
// depends on doaf_pkg and doaf_ram
//
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_data) takes one command per
//   transaction: write a byte, read a burst, clear, or reset the statistics.
//   output channel (o_out_valid / i_out_stall / o_out_data) returns one result
//   per write, clear, stats reset or empty read, one per byte of a read burst
//   (up to 64, last flagged); each carries level, percent, flags, counters.
//   a single-result command goes through the emit state into the output
//   register; each byte of a burst goes through the read-data state and then
//   the emit state, as the byte store has a registered read port. no new
//   command is taken until the last result of the current one has been
//   loaded into the output register.
//   a stalled result holds the output register; the next command is still
//   taken, and its result then holds the block until the stall clears.
//   reset (synchronous, active low) empties the fifo, clears the counters and
//   loads thresholds 1024, 256, 3072; the byte store is not cleared, as only
//   written bytes are read. thresholds are to be written through i_cfg_we /
//   i_cfg_index / i_cfg_data only while idle; nothing in the block checks this.
module drop_oldest_audio_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  doaf_pkg::t_in_item                  i_in_data,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output doaf_pkg::t_out_item                 o_out_data,
    // threshold register writes
    input  logic                                i_cfg_we,
    input  logic [doaf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [doaf_pkg::LVL_W-1:0]          i_cfg_data
);

    // sequencer states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_RD_DATA = 2'd1;
    localparam logic [1:0] S_EMIT    = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [doaf_pkg::PTR_W-1:0]        r_rptr, n_rptr;
    logic [doaf_pkg::PTR_W-1:0]        r_wptr, n_wptr;
    logic [doaf_pkg::LVL_W-1:0]        r_held, n_held;
    logic                              r_noted, n_noted;
    logic [doaf_pkg::CNT_W-1:0]        r_ovr, n_ovr;
    logic [doaf_pkg::CNT_W-1:0]        r_und, n_und;
    logic [doaf_pkg::TOT_W-1:0]        r_wtot, n_wtot;
    logic [doaf_pkg::TOT_W-1:0]        r_rtot, n_rtot;
    logic [doaf_pkg::BURST_W-1:0]      r_remain, n_remain;
    logic [doaf_pkg::STATUS_W-1:0]     r_status, n_status;
    logic                              r_last, n_last;
    logic [doaf_pkg::BYTE_W-1:0]       r_byte, n_byte;
    logic [doaf_pkg::LVL_W-1:0]        r_target, r_min, r_max;
    logic                              r_o_valid;
    doaf_pkg::t_out_item               r_out;

    logic                              in_acc;
    logic                              out_load;
    logic                              ram_we;
    logic [doaf_pkg::BYTE_W-1:0]       ram_q;
    logic [doaf_pkg::BURST_W-1:0]      want;
    logic [doaf_pkg::PROD_W-1:0]       pct_prod;
    logic [doaf_pkg::PCT_W-1:0]        pct;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_EMIT) && (!r_o_valid || !i_out_stall);

    // byte store, always reading at the read pointer
    doaf_ram #(
        .WIDTH (doaf_pkg::BYTE_W),
        .DEPTH (doaf_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (i_in_data.write_byte),
        .i_raddr (r_rptr),
        .o_rdata (ram_q)
    );

    // burst length clamped to 1 .. max burst
    always_comb begin
        if (i_in_data.read_length == '0) begin
            want = doaf_pkg::BURST_W'(1);
        end else if (i_in_data.read_length > doaf_pkg::BURST_W'(doaf_pkg::MAX_BURST)) begin
            want = doaf_pkg::BURST_W'(doaf_pkg::MAX_BURST);
        end else begin
            want = i_in_data.read_length;
        end
    end

    // percent full from the held count
    assign pct_prod = doaf_pkg::PROD_W'(r_held) * doaf_pkg::PROD_W'(doaf_pkg::PERCENT);
    assign pct      = doaf_pkg::PCT_W'(pct_prod / doaf_pkg::DEPTH);

    // command sequencer and state update
    always_comb begin
        logic noted_v;
        noted_v  = r_noted;
        n_state  = r_state;
        n_rptr   = r_rptr;
        n_wptr   = r_wptr;
        n_held   = r_held;
        n_noted  = r_noted;
        n_ovr    = r_ovr;
        n_und    = r_und;
        n_wtot   = r_wtot;
        n_rtot   = r_rtot;
        n_remain = r_remain;
        n_status = r_status;
        n_last   = r_last;
        n_byte   = r_byte;
        ram_we   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.mode)
                        doaf_pkg::MODE_WRITE: begin
                            noted_v = i_in_data.chunk_start ? 1'b0 : r_noted;
                            ram_we  = 1'b1;
                            n_wptr  = doaf_pkg::next_ptr(r_wptr);
                            n_wtot  = (r_wtot == '1) ? r_wtot : r_wtot + 1'b1;
                            if (r_held == doaf_pkg::LVL_W'(doaf_pkg::DEPTH)) begin
                                // full: drop the oldest byte, count once per chunk
                                n_rptr = doaf_pkg::next_ptr(r_rptr);
                                if (!noted_v) begin
                                    n_ovr   = (r_ovr == '1) ? r_ovr : r_ovr + 1'b1;
                                    noted_v = 1'b1;
                                end
                            end else begin
                                n_held = r_held + 1'b1;
                            end
                            n_noted  = noted_v;
                            n_status = doaf_pkg::ST_WRITTEN;
                            n_last   = 1'b1;
                            n_byte   = '0;
                            n_state  = S_EMIT;
                        end
                        doaf_pkg::MODE_READ: begin
                            if (r_held == '0) begin
                                if (i_in_data.may_wait) begin
                                    n_und    = (r_und == '1) ? r_und : r_und + 1'b1;
                                    n_status = doaf_pkg::ST_UNDERRUN;
                                end else begin
                                    n_status = doaf_pkg::ST_EMPTY;
                                end
                                n_last  = 1'b1;
                                n_byte  = '0;
                                n_state = S_EMIT;
                            end else begin
                                n_remain = (doaf_pkg::LVL_W'(want) < r_held) ?
                                           want : doaf_pkg::BURST_W'(r_held);
                                n_state  = S_RD_DATA;
                            end
                        end
                        doaf_pkg::MODE_CLEAR: begin
                            n_rptr   = '0;
                            n_wptr   = '0;
                            n_held   = '0;
                            n_noted  = 1'b0;
                            n_status = doaf_pkg::ST_CLEARED;
                            n_last   = 1'b1;
                            n_byte   = '0;
                            n_state  = S_EMIT;
                        end
                        doaf_pkg::MODE_STATS: begin
                            n_ovr    = '0;
                            n_und    = '0;
                            n_wtot   = '0;
                            n_rtot   = '0;
                            n_status = doaf_pkg::ST_STATS;
                            n_last   = 1'b1;
                            n_byte   = '0;
                            n_state  = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            // store data for the read pointer is valid here
            S_RD_DATA: begin
                n_byte   = ram_q;
                n_rptr   = doaf_pkg::next_ptr(r_rptr);
                n_held   = r_held - 1'b1;
                n_rtot   = (r_rtot == '1) ? r_rtot : r_rtot + 1'b1;
                n_status = doaf_pkg::ST_READ;
                n_last   = (r_remain == doaf_pkg::BURST_W'(1));
                n_remain = r_remain - 1'b1;
                n_state  = S_EMIT;
            end
            // wait for room in the output register
            S_EMIT: begin
                if (out_load) begin
                    n_state = (r_status == doaf_pkg::ST_READ && !r_last) ? S_RD_DATA : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rptr   <= '0;
            r_wptr   <= '0;
            r_held   <= '0;
            r_noted  <= 1'b0;
            r_ovr    <= '0;
            r_und    <= '0;
            r_wtot   <= '0;
            r_rtot   <= '0;
            r_remain <= '0;
            r_status <= doaf_pkg::ST_WRITTEN;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rptr   <= n_rptr;
            r_wptr   <= n_wptr;
            r_held   <= n_held;
            r_noted  <= n_noted;
            r_ovr    <= n_ovr;
            r_und    <= n_und;
            r_wtot   <= n_wtot;
            r_rtot   <= n_rtot;
            r_remain <= n_remain;
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

    // pending read byte
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= doaf_pkg::TARGET_RST;
            r_min    <= doaf_pkg::MIN_RST;
            r_max    <= doaf_pkg::MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                doaf_pkg::CFG_TARGET: r_target <= i_cfg_data;
                doaf_pkg::CFG_MIN:    r_min    <= i_cfg_data;
                doaf_pkg::CFG_MAX:    r_max    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.read_byte           <= r_byte;
            r_out.last                <= r_last;
            r_out.status              <= r_status;
            r_out.fill_level          <= r_held;
            r_out.fill_percent        <= pct;
            r_out.target_reached      <= (r_held >= r_target);
            r_out.below_min           <= (r_held < r_min);
            r_out.above_max           <= (r_held > r_max);
            r_out.overrun_count       <= r_ovr;
            r_out.underrun_count      <= r_und;
            r_out.bytes_written_total <= r_wtot;
            r_out.bytes_read_total    <= r_rtot;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

endmodule

/* hdl/doaf_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies; read of an address being written returns the old data
module doaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/doaf_checker.sv */
// port-level checker for the drop-oldest audio fifo, bound to the top level
// depends on doaf_pkg and drop_oldest_audio_fifo_defines.svh
`include "drop_oldest_audio_fifo_defines.svh"

module doaf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input doaf_pkg::t_out_item o_out_data
);

    // a stalled result stays put
    `DOAF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // only read data carries a byte
    `DOAF_ASSERT_SAME(a_byte_zero, o_out_valid && o_out_data.status != doaf_pkg::ST_READ, o_out_data.read_byte == '0)

    // level never exceeds the store depth
    `DOAF_ASSERT_SAME(a_level_bound, o_out_valid, o_out_data.fill_level <= doaf_pkg::LVL_W'(doaf_pkg::DEPTH))

    // a clear leaves an empty store
    `DOAF_ASSERT_SAME(a_clear_empty, o_out_valid && o_out_data.status == doaf_pkg::ST_CLEARED, o_out_data.fill_level == '0 && o_out_data.fill_percent == '0)

endmodule

bind drop_oldest_audio_fifo doaf_checker u_doaf_checker (.*);

/* tb/doaf_result_checker.sv */
`timescale 1ns / 100ps
// result checker for the drop-oldest audio fifo: follows accepted commands and
// threshold writes, predicts every result and compares it; depends on doaf_pkg
module doaf_result_checker
    import doaf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LVL_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_waiting
);

    // predicted fifo contents, pointers and statistics
    logic [BYTE_W-1:0] audio_mem [DEPTH];
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  wr_ptr;
    logic [LVL_W-1:0]  held;
    logic              drop_noted;
    logic [CNT_W-1:0]  overruns;
    logic [CNT_W-1:0]  underruns;
    logic [TOT_W-1:0]  wr_total;
    logic [TOT_W-1:0]  rd_total;
    logic [LVL_W-1:0]  target_lvl;
    logic [LVL_W-1:0]  min_lvl;
    logic [LVL_W-1:0]  max_lvl;

    t_out_item expected_results [$];
    int        mismatches = 0;

    // result fields taken from the state after the effect of this result
    function automatic t_out_item level_result(input logic [BYTE_W-1:0] b, input logic lst,
                                               input logic [STATUS_W-1:0] st);
        t_out_item r;
        r.read_byte           = b;
        r.last                = lst;
        r.status              = st;
        r.fill_level          = held;
        r.fill_percent        = PCT_W'((32'(held) * PERCENT) / DEPTH);
        r.target_reached      = (held >= target_lvl);
        r.below_min           = (held < min_lvl);
        r.above_max           = (held > max_lvl);
        r.overrun_count       = overruns;
        r.underrun_count      = underruns;
        r.bytes_written_total = wr_total;
        r.bytes_read_total    = rd_total;
        return r;
    endfunction

    // update the fifo for one command and queue the results it causes
    // (pointers are as wide as the depth, so plain increments wrap the ring)
    task automatic apply_command(input t_in_item c);
        int unsigned want;
        int unsigned n;
        case (c.mode)
            MODE_WRITE: begin
                if (c.chunk_start) drop_noted = 1'b0;
                // full: drop the oldest byte, count once per chunk
                if (held == LVL_W'(DEPTH)) begin
                    rd_ptr = rd_ptr + 1'b1;
                    held   = held - 1'b1;
                    if (!drop_noted) begin
                        if (overruns != '1) overruns = overruns + 1'b1;
                        drop_noted = 1'b1;
                    end
                end
                audio_mem[wr_ptr] = c.write_byte;
                wr_ptr = wr_ptr + 1'b1;
                held   = held + 1'b1;
                if (wr_total != '1) wr_total = wr_total + 1'b1;
                expected_results.push_back(level_result('0, 1'b1, ST_WRITTEN));
            end
            MODE_READ: begin
                want = c.read_length;
                if (want == 0) want = 1;
                if (want > MAX_BURST) want = MAX_BURST;
                if (held == 0) begin
                    if (c.may_wait) begin
                        if (underruns != '1) underruns = underruns + 1'b1;
                        expected_results.push_back(level_result('0, 1'b1, ST_UNDERRUN));
                    end else begin
                        expected_results.push_back(level_result('0, 1'b1, ST_EMPTY));
                    end
                end else begin
                    n = (want < held) ? want : held;
                    for (int unsigned i = 0; i < n; i++) begin
                        logic [BYTE_W-1:0] b;
                        b      = audio_mem[rd_ptr];
                        rd_ptr = rd_ptr + 1'b1;
                        held   = held - 1'b1;
                        if (rd_total != '1) rd_total = rd_total + 1'b1;
                        expected_results.push_back(level_result(b, i + 1 == n, ST_READ));
                    end
                end
            end
            MODE_CLEAR: begin
                rd_ptr     = '0;
                wr_ptr     = '0;
                held       = '0;
                drop_noted = 1'b0;
                expected_results.push_back(level_result('0, 1'b1, ST_CLEARED));
            end
            default: begin
                overruns  = '0;
                underruns = '0;
                wr_total  = '0;
                rd_total  = '0;
                expected_results.push_back(level_result('0, 1'b1, ST_STATS));
            end
        endcase
    endtask

    task automatic check_field(input string nm, input logic [TOT_W-1:0] exp_val,
                               input logic [TOT_W-1:0] act_val);
        if (act_val !== exp_val) begin
            mismatches++;
            if (mismatches <= 10)
                $display("doaf mismatch on %s at %0t: expected %0h, got %0h",
                         nm, $time, exp_val, act_val);
        end
    endtask

    // compare the oldest expectation against the result transaction
    task automatic check_result(input t_out_item act);
        t_out_item exp_r;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("doaf mismatch at %0t: result with no expectation, status %0d level %0d",
                         $time, act.status, act.fill_level);
        end else begin
            exp_r = expected_results.pop_front();
            check_field("read_byte", exp_r.read_byte, act.read_byte);
            check_field("last", exp_r.last, act.last);
            check_field("status", exp_r.status, act.status);
            check_field("fill_level", exp_r.fill_level, act.fill_level);
            check_field("fill_percent", exp_r.fill_percent, act.fill_percent);
            check_field("target_reached", exp_r.target_reached, act.target_reached);
            check_field("below_min", exp_r.below_min, act.below_min);
            check_field("above_max", exp_r.above_max, act.above_max);
            check_field("overrun_count", exp_r.overrun_count, act.overrun_count);
            check_field("underrun_count", exp_r.underrun_count, act.underrun_count);
            check_field("bytes_written_total", exp_r.bytes_written_total,
                        act.bytes_written_total);
            check_field("bytes_read_total", exp_r.bytes_read_total, act.bytes_read_total);
        end
    endtask

    // results are checked before the same edge's command is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_ptr     = '0;
            wr_ptr     = '0;
            held       = '0;
            drop_noted = 1'b0;
            overruns   = '0;
            underruns  = '0;
            wr_total   = '0;
            rd_total   = '0;
            target_lvl = TARGET_RST;
            min_lvl    = MIN_RST;
            max_lvl    = MAX_RST;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TARGET: target_lvl = i_cfg_data;
                    CFG_MIN:    min_lvl    = i_cfg_data;
                    CFG_MAX:    max_lvl    = i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_in_valid && !i_in_stall) apply_command(i_in_data);
        end
        o_waiting    <= expected_results.size();
        o_mismatches <= mismatches;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench top for the drop-oldest audio fifo: drives commands, threshold
// writes and result stalls; depends on doaf_pkg, the fifo and doaf_result_checker
module tb;
    import doaf_pkg::*;

    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 92;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LVL_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;

    int mismatches;
    int waiting;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_ask      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    drop_oldest_audio_fifo u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    doaf_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_waiting    (waiting)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result stalls: a requested long hold-off, otherwise random
    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen   <= hold_ask;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin
        #10000000;
        $display("drop_oldest_audio_fifo verification failed");
        $finish;
    end

    function automatic t_in_item write_cmd(input logic [BYTE_W-1:0] b, input logic start);
        t_in_item c;
        c             = '0;
        c.mode        = MODE_WRITE;
        c.write_byte  = b;
        c.chunk_start = start;
        return c;
    endfunction

    function automatic t_in_item read_cmd(input logic [BURST_W-1:0] len, input logic wt);
        t_in_item c;
        c             = '0;
        c.mode        = MODE_READ;
        c.read_length = len;
        c.may_wait    = wt;
        return c;
    endfunction

    function automatic t_in_item simple_cmd(input logic [MODE_W-1:0] m);
        t_in_item c;
        c      = '0;
        c.mode = m;
        return c;
    endfunction

    // mostly writes and short reads so the level wanders; unused fields are noise
    function automatic t_in_item random_cmd();
        t_in_item c;
        int       pick;
        c.write_byte  = BYTE_W'($urandom_range(0, 255));
        c.chunk_start = ($urandom_range(0, 3) == 0);
        c.may_wait    = 1'($urandom_range(0, 1));
        c.read_length = ($urandom_range(0, 3) == 0) ? BURST_W'($urandom_range(0, 127))
                                                    : BURST_W'($urandom_range(1, 4));
        pick = $urandom_range(0, 99);
        if (pick < 62)      c.mode = MODE_WRITE;
        else if (pick < 90) c.mode = MODE_READ;
        else if (pick < 94) c.mode = MODE_CLEAR;
        else                c.mode = MODE_STATS;
        return c;
    endfunction

    // one command transaction, with random idle cycles in front
    task automatic send_cmd(input t_in_item c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop sending until every expected result is back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_levels(input logic [LVL_W-1:0] tgt, input logic [LVL_W-1:0] mn,
                              input logic [LVL_W-1:0] mx);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TARGET;
        i_cfg_data  <= tgt;
        @(posedge i_clk);
        i_cfg_index <= CFG_MIN;
        i_cfg_data  <= mn;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX;
        i_cfg_data  <= mx;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty reads, odd lengths, clear and stats reset at reset thresholds
        send_cmd(read_cmd(7'd1, 1'b0));
        send_cmd(read_cmd(7'd5, 1'b1));
        send_cmd(write_cmd(8'h00, 1'b1));
        send_cmd(write_cmd(8'hff, 1'b0));
        send_cmd(write_cmd(8'ha5, 1'b0));
        send_cmd(write_cmd(8'h5a, 1'b1));
        send_cmd(read_cmd(7'd0, 1'b0));
        send_cmd(read_cmd(7'd127, 1'b1));
        send_cmd(read_cmd(7'd1, 1'b1));
        send_cmd(write_cmd(8'h01, 1'b1));
        send_cmd(write_cmd(8'h80, 1'b0));
        send_cmd(simple_cmd(MODE_CLEAR));
        send_cmd(read_cmd(7'd64, 1'b0));
        send_cmd(write_cmd(8'h7e, 1'b1));
        send_cmd(write_cmd(8'h81, 1'b0));
        send_cmd(simple_cmd(MODE_STATS));
        send_cmd(read_cmd(7'd65, 1'b0));
        send_cmd(read_cmd(7'd64, 1'b1));
        send_cmd(simple_cmd(MODE_STATS));
        send_cmd(simple_cmd(MODE_CLEAR));
        drain();

        // long result hold-off while the sender keeps offering writes
        set_levels(13'd16, 13'd8, 13'd24);
        hold_ask <= hold_ask + 1;
        for (int i = 0; i < 40; i++)
            send_cmd(write_cmd(BYTE_W'($urandom_range(0, 255)), i == 0));
        send_cmd(simple_cmd(MODE_STATS));
        repeat (2)
            send_cmd(read_cmd(7'd127, 1'($urandom_range(0, 1))));
        drain();

        // random phases under the four idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                    set_levels(13'd0, 13'd0, 13'd0);
                end
                1: begin
                    send_idle_pct = 59;
                    stall_pct    <= 0;
                    set_levels(LVL_W'($urandom_range(0, 24)), LVL_W'($urandom_range(0, 24)),
                               LVL_W'($urandom_range(0, 24)));
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct    <= 59;
                    set_levels(LVL_W'($urandom_range(0, 24)), LVL_W'($urandom_range(0, 24)),
                               LVL_W'($urandom_range(0, 24)));
                end
                default: begin
                    send_idle_pct = 30;
                    stall_pct    <= 30;
                    set_levels(LVL_W'($urandom_range(0, 24)), LVL_W'($urandom_range(0, 24)),
                               LVL_W'($urandom_range(0, 24)));
                end
            endcase
            repeat (RANDOM_ITEMS) send_cmd(random_cmd());
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && waiting == 0) begin
            $display("drop_oldest_audio_fifo verification clean");
        end else begin
            $display("drop_oldest_audio_fifo verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/doaf_pkg.sv
hdl/doaf_ram.sv
hdl/drop_oldest_audio_fifo.sv
hdl/doaf_checker.sv
tb/doaf_result_checker.sv
tb/tb.sv
